// ===== rtl/cpualu_pkg.sv =====
// Shared types and constants for the eight-bit processor ALU.
package cpualu_pkg;

    typedef enum logic [4:0] {
        OP_ADD8  = 5'd0,
        OP_ADC8  = 5'd1,
        OP_SUB8  = 5'd2,
        OP_SBC8  = 5'd3,
        OP_CP8   = 5'd4,
        OP_AND   = 5'd5,
        OP_OR    = 5'd6,
        OP_XOR   = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_ADD16 = 5'd10,
        OP_ADC16 = 5'd11,
        OP_SBC16 = 5'd12,
        OP_RLC   = 5'd13,
        OP_RRC   = 5'd14,
        OP_RL    = 5'd15,
        OP_RR    = 5'd16,
        OP_SLA   = 5'd17,
        OP_SRA   = 5'd18,
        OP_SLL   = 5'd19,
        OP_SRL   = 5'd20,
        OP_RLCA  = 5'd21,
        OP_RRCA  = 5'd22,
        OP_RLA   = 5'd23,
        OP_RRA   = 5'd24,
        OP_DAA   = 5'd25,
        OP_BIT   = 5'd26
    } op_t;

    // Bit positions in the flag byte.
    localparam int unsigned FL_C  = 0;
    localparam int unsigned FL_N  = 1;
    localparam int unsigned FL_PV = 2;
    localparam int unsigned FL_X  = 3;
    localparam int unsigned FL_H  = 4;
    localparam int unsigned FL_Y  = 5;
    localparam int unsigned FL_Z  = 6;
    localparam int unsigned FL_S  = 7;

    typedef struct packed {
        logic [4:0]  req_type;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_index;
        logic [7:0]  flags_in;
    } alu_req_t;

    typedef struct packed {
        logic [15:0] result;
        logic [7:0]  flags_out;
        logic        has_result;
    } alu_out_t;

endpackage

// ===== rtl/cpualu_core.sv =====
// Combinational datapath of the ALU: result, flag byte and write-back mark.
module cpualu_core (
    input  cpualu_pkg::alu_req_t req,
    output cpualu_pkg::alu_out_t rsp
);
    import cpualu_pkg::*;

    // S, Z, Y and X from an eight-bit value.
    function automatic logic [7:0] szxy(input logic [7:0] r);
        logic [7:0] f;
        f        = 8'h00;
        f[FL_S]  = r[7];
        f[FL_Z]  = (r == 8'h00);
        f[FL_Y]  = r[5];
        f[FL_X]  = r[3];
        return f;
    endfunction

    function automatic logic [7:0] logic_flags(input logic [7:0] r, input logic h);
        logic [7:0] f;
        f        = szxy(r);
        f[FL_H]  = h;
        f[FL_PV] = ~^r;
        return f;
    endfunction

    logic [7:0]  a;
    logic [7:0]  v;
    logic        cin;
    logic        add_c;
    logic        sub_c;
    logic        c16;
    logic [8:0]  add9;
    logic [4:0]  add_h;
    logic [8:0]  sub9;
    logic [4:0]  sub_h;
    logic [16:0] sum17;
    logic [12:0] sum_h;
    logic [16:0] diff17;
    logic [12:0] diff_h;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [2:0]  sh_k;
    logic        sh_co;
    logic [7:0]  sh_res;
    logic [7:0]  daa_corr;
    logic        daa_c;
    logic [7:0]  daa_res;
    logic        daa_h;
    logic [4:0]  daa_lo;
    logic        bit_set;
    logic [15:0] res;
    logic [7:0]  f;
    logic        wr;

    assign a   = req.operand_a[7:0];
    assign v   = req.operand_b[7:0];
    assign cin = req.flags_in[FL_C];

    assign add_c = (req.req_type == OP_ADC8) & cin;
    assign sub_c = (req.req_type == OP_SBC8) & cin;
    assign c16   = (req.req_type == OP_ADC16) & cin;

    assign add9  = {1'b0, a} + {1'b0, v} + {8'h00, add_c};
    assign add_h = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'h0, add_c};
    assign sub9  = {1'b0, a} - {1'b0, v} - {8'h00, sub_c};
    assign sub_h = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'h0, sub_c};

    assign sum17  = {1'b0, req.operand_a} + {1'b0, req.operand_b} + {16'h0000, c16};
    assign sum_h  = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]}
                  + {12'h000, c16};
    assign diff17 = {1'b0, req.operand_a} - {1'b0, req.operand_b} - {16'h0000, cin};
    assign diff_h = {1'b0, req.operand_a[11:0]} - {1'b0, req.operand_b[11:0]}
                  - {12'h000, cin};

    assign inc8 = a + 8'd1;
    assign dec8 = a - 8'd1;

    // The CB shifts and the accumulator rotates share one shifter; even
    // selections shift left and odd ones shift right.
    always_comb
    begin
        if (req.req_type <= OP_SRL)
        begin
            sh_k = 3'(req.req_type - OP_RLC);
        end
        else
        begin
            sh_k = 3'(req.req_type - OP_RLCA);
        end
        sh_co = sh_k[0] ? a[0] : a[7];
        unique case (sh_k)
            3'd0:    sh_res = {a[6:0], sh_co};
            3'd1:    sh_res = {sh_co, a[7:1]};
            3'd2:    sh_res = {a[6:0], cin};
            3'd3:    sh_res = {cin, a[7:1]};
            3'd4:    sh_res = {a[6:0], 1'b0};
            3'd5:    sh_res = {a[7], a[7:1]};
            3'd6:    sh_res = {a[6:0], 1'b1};
            default: sh_res = {1'b0, a[7:1]};
        endcase
    end

    // Decimal adjust: the correction depends on H, C and the digits, and
    // is subtracted after a subtraction, otherwise added.
    always_comb
    begin
        daa_corr = 8'h00;
        daa_c    = 1'b0;
        if (req.flags_in[FL_H] || (a[3:0] > 4'h9))
        begin
            daa_corr[3:0] = 4'h6;
        end
        if (cin || (a > 8'h99))
        begin
            daa_corr[7:4] = 4'h6;
            daa_c         = 1'b1;
        end
        daa_lo = {1'b0, a[3:0]} + {1'b0, daa_corr[3:0]};
        if (req.flags_in[FL_N])
        begin
            daa_res = a - daa_corr;
            daa_h   = req.flags_in[FL_H] && (a[3:0] < 4'h6);
        end
        else
        begin
            daa_res = a + daa_corr;
            daa_h   = daa_lo[4];
        end
    end

    assign bit_set = a[req.bit_index];

    always_comb
    begin
        res = 16'h0000;
        f   = req.flags_in;
        wr  = 1'b1;
        unique case (op_t'(req.req_type))
            OP_ADD8, OP_ADC8:
            begin
                res      = {8'h00, add9[7:0]};
                f        = szxy(add9[7:0]);
                f[FL_H]  = add_h[4];
                f[FL_PV] = ~(a[7] ^ v[7]) & (a[7] ^ add9[7]);
                f[FL_C]  = add9[8];
            end
            OP_SUB8, OP_SBC8, OP_CP8:
            begin
                res      = {8'h00, sub9[7:0]};
                f        = szxy(sub9[7:0]);
                f[FL_N]  = 1'b1;
                f[FL_H]  = sub_h[4];
                f[FL_PV] = (a[7] ^ v[7]) & (a[7] ^ sub9[7]);
                f[FL_C]  = sub9[8];
                if (req.req_type == OP_CP8)
                begin
                    // Compare takes X and Y from the operand, not the difference.
                    f[FL_Y] = v[5];
                    f[FL_X] = v[3];
                    res     = 16'h0000;
                    wr      = 1'b0;
                end
            end
            OP_AND:
            begin
                res = {8'h00, a & v};
                f   = logic_flags(a & v, 1'b1);
            end
            OP_OR:
            begin
                res = {8'h00, a | v};
                f   = logic_flags(a | v, 1'b0);
            end
            OP_XOR:
            begin
                res = {8'h00, a ^ v};
                f   = logic_flags(a ^ v, 1'b0);
            end
            OP_INC:
            begin
                res      = {8'h00, inc8};
                f        = szxy(inc8);
                f[FL_C]  = cin;
                f[FL_H]  = (a[3:0] == 4'hF);
                f[FL_PV] = (a == 8'h7F);
            end
            OP_DEC:
            begin
                res      = {8'h00, dec8};
                f        = szxy(dec8);
                f[FL_C]  = cin;
                f[FL_N]  = 1'b1;
                f[FL_H]  = (a[3:0] == 4'h0);
                f[FL_PV] = (a == 8'h80);
            end
            OP_ADD16:
            begin
                res      = sum17[15:0];
                f        = 8'h00;
                f[FL_S]  = req.flags_in[FL_S];
                f[FL_Z]  = req.flags_in[FL_Z];
                f[FL_PV] = req.flags_in[FL_PV];
                f[FL_H]  = sum_h[12];
                f[FL_C]  = sum17[16];
                f[FL_Y]  = sum17[13];
                f[FL_X]  = sum17[11];
            end
            OP_ADC16:
            begin
                res      = sum17[15:0];
                f        = 8'h00;
                f[FL_S]  = sum17[15];
                f[FL_Z]  = (sum17[15:0] == 16'h0000);
                f[FL_Y]  = sum17[13];
                f[FL_X]  = sum17[11];
                f[FL_H]  = sum_h[12];
                f[FL_PV] = ~(req.operand_a[15] ^ req.operand_b[15])
                         & (req.operand_a[15] ^ sum17[15]);
                f[FL_C]  = sum17[16];
            end
            OP_SBC16:
            begin
                res      = diff17[15:0];
                f        = 8'h00;
                f[FL_S]  = diff17[15];
                f[FL_Z]  = (diff17[15:0] == 16'h0000);
                f[FL_Y]  = diff17[13];
                f[FL_X]  = diff17[11];
                f[FL_N]  = 1'b1;
                f[FL_H]  = diff_h[12];
                f[FL_PV] = (req.operand_a[15] ^ req.operand_b[15])
                         & (req.operand_a[15] ^ diff17[15]);
                f[FL_C]  = diff17[16];
            end
            OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SLL, OP_SRL:
            begin
                res     = {8'h00, sh_res};
                f       = logic_flags(sh_res, 1'b0);
                f[FL_C] = sh_co;
            end
            OP_RLCA, OP_RRCA, OP_RLA, OP_RRA:
            begin
                // Accumulator rotates keep S, Z and P/V.
                res     = {8'h00, sh_res};
                f       = 8'h00;
                f[FL_S] = req.flags_in[FL_S];
                f[FL_Z] = req.flags_in[FL_Z];
                f[FL_PV] = req.flags_in[FL_PV];
                f[FL_Y] = sh_res[5];
                f[FL_X] = sh_res[3];
                f[FL_C] = sh_co;
            end
            OP_DAA:
            begin
                res     = {8'h00, daa_res};
                f       = logic_flags(daa_res, daa_h);
                f[FL_N] = req.flags_in[FL_N];
                f[FL_C] = daa_c;
            end
            OP_BIT:
            begin
                f        = 8'h00;
                f[FL_C]  = cin;
                f[FL_H]  = 1'b1;
                f[FL_Y]  = a[5];
                f[FL_X]  = a[3];
                f[FL_Z]  = ~bit_set;
                f[FL_PV] = ~bit_set;
                f[FL_S]  = (req.bit_index == 3'd7) & bit_set;
                wr       = 1'b0;
            end
            default:
            begin
                // Undefined operation codes leave the flags alone.
                res = 16'h0000;
                f   = req.flags_in;
                wr  = 1'b0;
            end
        endcase
    end

    assign rsp.result     = res;
    assign rsp.flags_out  = f;
    assign rsp.has_result = wr;

endmodule

// ===== rtl/cpu_alu_with_flags.sv =====
// Top level of the eight-bit processor ALU: request register, datapath, result register.
//
//   Channel   Handshake              Payload
//   request   req_valid / req_ready  req_type, operand_a, operand_b, bit_index, flags_in
//   result    res_valid / res_ready  result, flags_out, has_result
//
// A request is registered on acceptance and its result is written to the result
// register once that register is free; one request is taken every cycle while
// the result register is free. The ALU datapath between the two registers sets the
// clock period. Reset clears only the two valid flags. When the result is not
// taken, both stages hold and req_ready falls once the request stage is full.
module cpu_alu_with_flags (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [4:0]  req_type,
    input  logic [15:0] operand_a,
    input  logic [15:0] operand_b,
    input  logic [2:0]  bit_index,
    input  logic [7:0]  flags_in,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [15:0] result,
    output logic [7:0]  flags_out,
    output logic        has_result
);
    import cpualu_pkg::*;

    logic     req_valid_reg;
    logic     req_valid_next;
    alu_req_t req_reg;
    logic     res_valid_reg;
    logic     res_valid_next;
    alu_out_t res_reg;
    alu_out_t alu_out;
    logic     res_free;

    assign res_free  = ~res_valid_reg | res_ready;
    assign req_ready = ~req_valid_reg | res_free;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        res_valid_next = res_valid_reg;
        if (req_ready)
        begin
            req_valid_next = req_valid;
        end
        if (res_free)
        begin
            res_valid_next = req_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg.req_type  <= req_type;
            req_reg.operand_a <= operand_a;
            req_reg.operand_b <= operand_b;
            req_reg.bit_index <= bit_index;
            req_reg.flags_in  <= flags_in;
        end
        if (req_valid_reg && res_free)
        begin
            res_reg <= alu_out;
        end
    end

    cpualu_core u_core (
        .req (req_reg),
        .rsp (alu_out)
    );

    assign res_valid  = res_valid_reg;
    assign result     = res_reg.result;
    assign flags_out  = res_reg.flags_out;
    assign has_result = res_reg.has_result;

endmodule

// ===== sim/tb_cpu_alu_with_flags.sv =====
// Self-checking testbench for the processor ALU: directed table, then random requests.
module tb_cpu_alu_with_flags;
    import cpualu_pkg::*;

    // Operation codes past OP_BIT carry no meaning and must leave the flags untouched.
    localparam logic [4:0] CODE_SPARE_FIRST = 5'd27;
    localparam logic [4:0] CODE_SPARE_LAST  = 5'd31;
    localparam int RANDOM_REQUESTS = 750;
    localparam int MAX_WAIT        = 12;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 200000;

    typedef struct packed {
        alu_req_t req;
        logic     typed;
        alu_out_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic [4:0]  req_type;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [7:0]  flags_in;
    logic        res_valid;
    logic        res_ready;
    logic [15:0] result;
    logic [7:0]  flags_out;
    logic        has_result;

    // Typed expectation travelling alongside the request currently offered.
    logic        row_typed;
    alu_out_t    row_want;

    bit          calm;
    int          errors;
    int          cycle_count;
    alu_out_t    pending_results[$];
    stim_row_t   directed_rows[$];

    cpu_alu_with_flags dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_type   (req_type),
        .operand_a  (operand_a),
        .operand_b  (operand_b),
        .bit_index  (bit_index),
        .flags_in   (flags_in),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .result     (result),
        .flags_out  (flags_out),
        .has_result (has_result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Sign, zero and the two undocumented copies of bits 5 and 3.
    function automatic logic [7:0] sign_zero_xy(input logic [7:0] v);
        logic [7:0] f;
        f = 8'h00;
        f[FL_S] = v[7];
        f[FL_Z] = (v == 8'h00);
        f[FL_Y] = v[5];
        f[FL_X] = v[3];
        return f;
    endfunction

    function automatic logic [7:0] logic_flags(input logic [7:0] v, input logic h);
        logic [7:0] f;
        f = sign_zero_xy(v);
        f[FL_H]  = h;
        f[FL_PV] = ~^v;
        return f;
    endfunction

    function automatic alu_out_t compute_alu(input alu_req_t q);
        alu_out_t    o;
        logic [15:0] wa;
        logic [15:0] wb;
        logic [7:0]  a;
        logic [7:0]  v;
        logic [7:0]  r8;
        logic [7:0]  f;
        logic [7:0]  fi;
        logic [7:0]  corr;
        logic [8:0]  s9;
        logic [16:0] s17;
        logic [4:0]  h5;
        logic [12:0] h13;
        logic [2:0]  k;
        logic        cin;
        logic        c;
        logic        co;
        logic        nc;
        logic        nh;
        wa  = q.operand_a;
        wb  = q.operand_b;
        a   = wa[7:0];
        v   = wb[7:0];
        fi  = q.flags_in;
        cin = fi[FL_C];
        o.result     = 16'h0000;
        o.flags_out  = fi;
        o.has_result = 1'b1;
        case (q.req_type)
            OP_ADD8, OP_ADC8:
            begin
                c  = (q.req_type == OP_ADC8) ? cin : 1'b0;
                s9 = {1'b0, a} + {1'b0, v} + {8'h00, c};
                h5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'h0, c};
                r8 = s9[7:0];
                f  = sign_zero_xy(r8);
                f[FL_H]  = h5[4];
                f[FL_PV] = ~(a[7] ^ v[7]) & (a[7] ^ r8[7]);
                f[FL_C]  = s9[8];
                o.result    = {8'h00, r8};
                o.flags_out = f;
            end
            OP_SUB8, OP_SBC8, OP_CP8:
            begin
                c  = (q.req_type == OP_SBC8) ? cin : 1'b0;
                s9 = {1'b0, a} - {1'b0, v} - {8'h00, c};
                h5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'h0, c};
                r8 = s9[7:0];
                f  = sign_zero_xy(r8);
                f[FL_N]  = 1'b1;
                f[FL_H]  = h5[4];
                f[FL_PV] = (a[7] ^ v[7]) & (a[7] ^ r8[7]);
                f[FL_C]  = s9[8];
                if (q.req_type == OP_CP8)
                begin
                    // Compare copies X and Y from the operand, not from the difference.
                    f[FL_Y] = v[5];
                    f[FL_X] = v[3];
                    o.has_result = 1'b0;
                end
                else
                    o.result = {8'h00, r8};
                o.flags_out = f;
            end
            OP_AND:
            begin
                o.result    = {8'h00, a & v};
                o.flags_out = logic_flags(a & v, 1'b1);
            end
            OP_OR:
            begin
                o.result    = {8'h00, a | v};
                o.flags_out = logic_flags(a | v, 1'b0);
            end
            OP_XOR:
            begin
                o.result    = {8'h00, a ^ v};
                o.flags_out = logic_flags(a ^ v, 1'b0);
            end
            OP_INC, OP_DEC:
            begin
                if (q.req_type == OP_INC)
                begin
                    r8 = a + 8'h01;
                    f  = sign_zero_xy(r8);
                    f[FL_H]  = (a[3:0] == 4'hF);
                    f[FL_PV] = (a == 8'h7F);
                end
                else
                begin
                    r8 = a - 8'h01;
                    f  = sign_zero_xy(r8);
                    f[FL_N]  = 1'b1;
                    f[FL_H]  = (a[3:0] == 4'h0);
                    f[FL_PV] = (a == 8'h80);
                end
                f[FL_C] = cin;
                o.result    = {8'h00, r8};
                o.flags_out = f;
            end
            OP_ADD16:
            begin
                s17 = {1'b0, wa} + {1'b0, wb};
                h13 = {1'b0, wa[11:0]} + {1'b0, wb[11:0]};
                f = 8'h00;
                f[FL_S]  = fi[FL_S];
                f[FL_Z]  = fi[FL_Z];
                f[FL_PV] = fi[FL_PV];
                f[FL_H]  = h13[12];
                f[FL_C]  = s17[16];
                f[FL_Y]  = s17[13];
                f[FL_X]  = s17[11];
                o.result    = s17[15:0];
                o.flags_out = f;
            end
            OP_ADC16, OP_SBC16:
            begin
                f = 8'h00;
                if (q.req_type == OP_ADC16)
                begin
                    s17 = {1'b0, wa} + {1'b0, wb} + {16'h0000, cin};
                    h13 = {1'b0, wa[11:0]} + {1'b0, wb[11:0]} + {12'h000, cin};
                    f[FL_PV] = ~(wa[15] ^ wb[15]) & (wa[15] ^ s17[15]);
                end
                else
                begin
                    s17 = {1'b0, wa} - {1'b0, wb} - {16'h0000, cin};
                    h13 = {1'b0, wa[11:0]} - {1'b0, wb[11:0]} - {12'h000, cin};
                    f[FL_PV] = (wa[15] ^ wb[15]) & (wa[15] ^ s17[15]);
                    f[FL_N]  = 1'b1;
                end
                f[FL_S] = s17[15];
                f[FL_Z] = (s17[15:0] == 16'h0000);
                f[FL_Y] = s17[13];
                f[FL_X] = s17[11];
                f[FL_H] = h13[12];
                f[FL_C] = s17[16];
                o.result    = s17[15:0];
                o.flags_out = f;
            end
            OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SLL, OP_SRL,
            OP_RLCA, OP_RRCA, OP_RLA, OP_RRA:
            begin
                k  = (q.req_type <= OP_SRL) ? 3'(q.req_type - OP_RLC)
                                            : 3'(q.req_type - OP_RLCA);
                co = (k[0] == 1'b0) ? a[7] : a[0];
                case (k)
                    3'd0: r8 = {a[6:0], co};
                    3'd1: r8 = {co, a[7:1]};
                    3'd2: r8 = {a[6:0], cin};
                    3'd3: r8 = {cin, a[7:1]};
                    3'd4: r8 = {a[6:0], 1'b0};
                    3'd5: r8 = {a[7], a[7:1]};
                    3'd6: r8 = {a[6:0], 1'b1};
                    default: r8 = {1'b0, a[7:1]};
                endcase
                if (q.req_type <= OP_SRL)
                    f = logic_flags(r8, 1'b0);
                else
                begin
                    // The accumulator forms keep S, Z and P/V from the incoming flags.
                    f = 8'h00;
                    f[FL_S]  = fi[FL_S];
                    f[FL_Z]  = fi[FL_Z];
                    f[FL_PV] = fi[FL_PV];
                    f[FL_Y]  = r8[5];
                    f[FL_X]  = r8[3];
                end
                f[FL_C] = co;
                o.result    = {8'h00, r8};
                o.flags_out = f;
            end
            OP_DAA:
            begin
                corr = 8'h00;
                nc   = 1'b0;
                if (fi[FL_H] || a[3:0] > 4'd9)
                    corr = corr | 8'h06;
                if (cin || a > 8'h99)
                begin
                    corr = corr | 8'h60;
                    nc   = 1'b1;
                end
                if (fi[FL_N])
                begin
                    r8 = a - corr;
                    nh = fi[FL_H] && (a[3:0] < 4'd6);
                end
                else
                begin
                    r8 = a + corr;
                    h5 = {1'b0, a[3:0]} + {1'b0, corr[3:0]};
                    nh = h5[4];
                end
                f = logic_flags(r8, nh);
                f[FL_N] = fi[FL_N];
                f[FL_C] = nc;
                o.result    = {8'h00, r8};
                o.flags_out = f;
            end
            OP_BIT:
            begin
                f = 8'h00;
                f[FL_C] = cin;
                f[FL_H] = 1'b1;
                f[FL_Y] = a[5];
                f[FL_X] = a[3];
                if (!a[q.bit_index])
                begin
                    f[FL_Z]  = 1'b1;
                    f[FL_PV] = 1'b1;
                end
                if (q.bit_index == 3'd7 && a[7])
                    f[FL_S] = 1'b1;
                o.flags_out  = f;
                o.has_result = 1'b0;
            end
            default:
                o.has_result = 1'b0;
        endcase
        return o;
    endfunction

    task automatic add_row(input logic [4:0] code, input logic [15:0] a, input logic [15:0] b,
                           input logic [2:0] bi, input logic [7:0] fl, input logic typed,
                           input logic [15:0] want_res, input logic [7:0] want_fl,
                           input logic want_has);
        stim_row_t row;
        row.req   = {code, a, b, bi, fl};
        row.typed = typed;
        row.want  = {want_res, want_fl, want_has};
        directed_rows.push_back(row);
    endtask

    function automatic logic [15:0] pick_word();
        logic [7:0] hi;
        hi = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return {hi, 8'h7F};
            3: return {hi, 8'h80};
            4: return ($urandom_range(0, 1) == 0) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [7:0] pick_bcd();
        logic [3:0] tens;
        logic [3:0] units;
        tens  = 4'($urandom_range(0, 9));
        units = 4'($urandom_range(0, 9));
        return {tens, units};
    endfunction

    // Offers one request, holding it until the block takes it; returns on a falling edge.
    task automatic send_request(input stim_row_t row);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= row.req.req_type;
        operand_a <= row.req.operand_a;
        operand_b <= row.req.operand_b;
        bit_index <= row.req.bit_index;
        flags_in  <= row.req.flags_in;
        row_typed <= row.typed;
        row_want  <= row.want;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    // Result side: drops res_ready for a random stall before every result, except in calm stretches.
    initial
    begin
        int stall;
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_valid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        alu_out_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result 0x%04h arrived with no request outstanding", result);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result !== want.result)
                begin
                    $error("result: expected 0x%04h, got 0x%04h", want.result, result);
                    errors++;
                end
                if (flags_out !== want.flags_out)
                begin
                    $error("flags_out: expected 0x%02h, got 0x%02h", want.flags_out, flags_out);
                    errors++;
                end
                if (has_result !== want.has_result)
                begin
                    $error("has_result: expected %0b, got %0b", want.has_result, has_result);
                    errors++;
                end
            end
        end
        if (rst_n && req_valid && req_ready)
            pending_results.push_back(row_typed ? row_want
                : compute_alu({req_type, operand_a, operand_b, bit_index, flags_in}));
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        stim_row_t row;
        alu_out_t  prior;
        int        code;
        errors    = 0;
        calm      = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_type  = OP_ADD8;
        operand_a = 16'h0000;
        operand_b = 16'h0000;
        bit_index = 3'd0;
        flags_in  = 8'h00;
        row_typed = 1'b0;
        row_want  = '0;

        // Directed table; the rows with a typed answer are the ones that can be worked by hand.
        add_row(OP_ADD8,  16'h0000, 16'h0000, 3'd0, 8'h00, 1'b1, 16'h0000, 8'h40, 1'b1);
        add_row(OP_ADD8,  16'h12FF, 16'hAB01, 3'd0, 8'h00, 1'b1, 16'h0000, 8'h51, 1'b1);
        add_row(OP_ADD8,  16'h007F, 16'h0001, 3'd0, 8'h00, 1'b1, 16'h0080, 8'h94, 1'b1);
        add_row(OP_ADC8,  16'h00FF, 16'h00FF, 3'd0, 8'hFF, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_SUB8,  16'h0000, 16'h0001, 3'd0, 8'h00, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_SBC8,  16'h0080, 16'h007F, 3'd0, 8'h01, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_CP8,   16'hFF10, 16'h0028, 3'd0, 8'h00, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_AND,   16'h00F0, 16'h000F, 3'd0, 8'hFF, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_OR,    16'h0000, 16'h0000, 3'd0, 8'hFF, 1'b1, 16'h0000, 8'h44, 1'b1);
        add_row(OP_XOR,   16'hFFFF, 16'hFFFF, 3'd0, 8'h00, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_INC,   16'h00FF, 16'hFFFF, 3'd0, 8'h00, 1'b1, 16'h0000, 8'h50, 1'b1);
        add_row(OP_DEC,   16'h0080, 16'h0000, 3'd0, 8'h00, 1'b1, 16'h007F, 8'h3E, 1'b1);
        add_row(OP_ADD16, 16'hFFFF, 16'h0001, 3'd0, 8'h00, 1'b1, 16'h0000, 8'h11, 1'b1);
        add_row(OP_ADC16, 16'h7FFF, 16'h0000, 3'd0, 8'h01, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_SBC16, 16'h0000, 16'hFFFF, 3'd0, 8'h01, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_RLC,   16'h0081, 16'h0000, 3'd0, 8'h00, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_RRC,   16'h0001, 16'h0000, 3'd0, 8'hFF, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_RL,    16'h0080, 16'h0000, 3'd0, 8'h01, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_RR,    16'h0001, 16'h0000, 3'd0, 8'h01, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_SLA,   16'h00FF, 16'h0000, 3'd0, 8'h00, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_SRA,   16'h0080, 16'h0000, 3'd0, 8'h00, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_SLL,   16'h0000, 16'h0000, 3'd0, 8'h00, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_SRL,   16'h0001, 16'h0000, 3'd0, 8'hFE, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_RLCA,  16'h0080, 16'h0000, 3'd0, 8'hC4, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_RRCA,  16'h0001, 16'h0000, 3'd0, 8'h00, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_RLA,   16'h0080, 16'h0000, 3'd0, 8'h01, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_RRA,   16'h0001, 16'h0000, 3'd0, 8'hFF, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_DAA,   16'h009A, 16'h0000, 3'd0, 8'h00, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_DAA,   16'h0099, 16'h0000, 3'd0, 8'h13, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(OP_BIT,   16'h0080, 16'h0000, 3'd7, 8'h00, 1'b1, 16'h0000, 8'h90, 1'b0);
        add_row(OP_BIT,   16'h0000, 16'h0000, 3'd3, 8'h01, 1'b0, 16'h0000, 8'h00, 1'b0);
        add_row(CODE_SPARE_FIRST, 16'h1234, 16'h5678, 3'd0, 8'hA5,
                1'b1, 16'h0000, 8'hA5, 1'b0);
        add_row(CODE_SPARE_LAST,  16'hFFFF, 16'hFFFF, 3'd7, 8'h5A,
                1'b1, 16'h0000, 8'h5A, 1'b0);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i]);

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                calm = ~calm;
            code = ($urandom_range(0, 15) == 0)
                ? $urandom_range(CODE_SPARE_FIRST, CODE_SPARE_LAST)
                : $urandom_range(OP_ADD8, OP_BIT);
            row.req.req_type  = 5'(code);
            row.req.operand_a = pick_word();
            row.req.operand_b = pick_word();
            row.req.bit_index = 3'($urandom_range(0, 7));
            row.req.flags_in  = 8'($urandom_range(0, 255));
            row.typed = 1'b0;
            row.want  = '0;
            // DAA mostly follows a real BCD addition or subtraction, as it does in use.
            if (row.req.req_type == OP_DAA && $urandom_range(0, 3) != 0)
            begin
                prior = compute_alu({($urandom_range(0, 1) == 0) ? OP_ADD8 : OP_SUB8,
                                     {8'h00, pick_bcd()}, {8'h00, pick_bcd()}, 3'd0, 8'h00});
                row.req.operand_a = prior.result;
                row.req.flags_in  = prior.flags_out;
            end
            send_request(row);
        end

        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
